@@ rtl/q2rm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2rm_pkg
// Types and constants shared by the quaternion to rotation matrix pipeline.
// ----------------------------------------------------------------------------
package q2rm_pkg;

    localparam int OUT_FRAC_BITS = 30;
    localparam int COMP_W        = 32;
    localparam int ELEM_W        = 32;
    localparam int N_ELEM        = 9;
    localparam int N_PROD        = 10;
    localparam int PROD_W        = 62;
    localparam int NUM_W         = 64;
    localparam int DEN_W         = 63;
    localparam int REM_W         = 64;
    localparam int QUO_STEPS     = OUT_FRAC_BITS + 1;
    localparam int QUO_W         = OUT_FRAC_BITS + 2;
    localparam int MAG_W         = OUT_FRAC_BITS + 1;

    localparam logic signed [COMP_W-1:0] BIG_LIMIT = COMP_W'(1) << 30;

    // product slots
    localparam int P_WW = 0;
    localparam int P_XX = 1;
    localparam int P_YY = 2;
    localparam int P_ZZ = 3;
    localparam int P_XY = 4;
    localparam int P_WZ = 5;
    localparam int P_XZ = 6;
    localparam int P_WY = 7;
    localparam int P_YZ = 8;
    localparam int P_WX = 9;

    typedef struct packed {
        logic signed [COMP_W-1:0] quat_w;
        logic signed [COMP_W-1:0] quat_x;
        logic signed [COMP_W-1:0] quat_y;
        logic signed [COMP_W-1:0] quat_z;
    } quat_in_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] elem_00;
        logic signed [ELEM_W-1:0] elem_01;
        logic signed [ELEM_W-1:0] elem_02;
        logic signed [ELEM_W-1:0] elem_10;
        logic signed [ELEM_W-1:0] elem_11;
        logic signed [ELEM_W-1:0] elem_12;
        logic signed [ELEM_W-1:0] elem_20;
        logic signed [ELEM_W-1:0] elem_21;
        logic signed [ELEM_W-1:0] elem_22;
        logic                     zero_length;
    } rot_out_t;

endpackage

@@ rtl/quaternion_to_rotation_matrix.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// transactions are accepted at one per cycle unless the pipe is halted by a
// full skid register; a restoring divider (one quotient bit per stage for all
// nine elements) sits behind the range-check, square/product and numerator stages.
// reset (aresetn, synchronous, active low) clears all valid bits; data is
// not reset.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix
    import q2rm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  quat_in_t s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output rot_out_t m_data
);

    // global pipeline enable: the skid register absorbs one result while the
    // output register waits, so the pipe only halts when both are full
    logic en;
    logic skid_v_reg;
    assign en      = !skid_v_reg;
    assign s_ready = en;

    // ------------------------------------------------------------------
    // stage 1: range check and optional halving of all components
    // ------------------------------------------------------------------
    logic signed [COMP_W-1:0] c_in [4];
    logic signed [COMP_W-1:0] c1_next [4];
    logic signed [COMP_W-1:0] c1_reg [4];
    logic                     big;
    logic                     zero1_next, zero1_reg, v1_reg;

    always_comb begin
        c_in[0] = s_data.quat_w;
        c_in[1] = s_data.quat_x;
        c_in[2] = s_data.quat_y;
        c_in[3] = s_data.quat_z;
        big = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (c_in[i] >= BIG_LIMIT || c_in[i] <= -BIG_LIMIT) begin
                big = 1'b1;
            end
        end
        for (int i = 0; i < 4; i++) begin
            c1_next[i] = big ? (c_in[i] >>> 1) : c_in[i];
        end
        zero1_next = (c_in[0] == '0) && (c_in[1] == '0) &&
                     (c_in[2] == '0) && (c_in[3] == '0);
    end

    // ------------------------------------------------------------------
    // stage 2: squares and cross products
    // ------------------------------------------------------------------
    logic signed [2*COMP_W-1:0] full_p [N_PROD];
    logic signed [PROD_W-1:0]   p2_reg [N_PROD];
    logic                       zero2_reg, v2_reg;

    always_comb begin
        full_p[P_WW] = c1_reg[0] * c1_reg[0];
        full_p[P_XX] = c1_reg[1] * c1_reg[1];
        full_p[P_YY] = c1_reg[2] * c1_reg[2];
        full_p[P_ZZ] = c1_reg[3] * c1_reg[3];
        full_p[P_XY] = c1_reg[1] * c1_reg[2];
        full_p[P_WZ] = c1_reg[0] * c1_reg[3];
        full_p[P_XZ] = c1_reg[1] * c1_reg[3];
        full_p[P_WY] = c1_reg[0] * c1_reg[2];
        full_p[P_YZ] = c1_reg[2] * c1_reg[3];
        full_p[P_WX] = c1_reg[0] * c1_reg[1];
    end

    // ------------------------------------------------------------------
    // stage 3: norm and the nine numerators
    // ------------------------------------------------------------------
    logic signed [NUM_W-1:0] pe [N_PROD];
    logic signed [NUM_W-1:0] num3_next [N_ELEM];
    logic signed [NUM_W-1:0] num3_reg [N_ELEM];
    logic [DEN_W-1:0]        den3_next, den3_reg;
    logic                    zero3_reg, v3_reg;

    always_comb begin
        for (int i = 0; i < N_PROD; i++) begin
            pe[i] = NUM_W'(p2_reg[i]);
        end
        den3_next = DEN_W'($unsigned(pe[P_WW])) + DEN_W'($unsigned(pe[P_XX])) +
                    DEN_W'($unsigned(pe[P_YY])) + DEN_W'($unsigned(pe[P_ZZ]));
        num3_next[0] = (pe[P_WW] + pe[P_XX]) - (pe[P_YY] + pe[P_ZZ]);
        num3_next[1] = (pe[P_XY] - pe[P_WZ]) <<< 1;
        num3_next[2] = (pe[P_XZ] + pe[P_WY]) <<< 1;
        num3_next[3] = (pe[P_XY] + pe[P_WZ]) <<< 1;
        num3_next[4] = (pe[P_WW] + pe[P_YY]) - (pe[P_XX] + pe[P_ZZ]);
        num3_next[5] = (pe[P_YZ] - pe[P_WX]) <<< 1;
        num3_next[6] = (pe[P_XZ] - pe[P_WY]) <<< 1;
        num3_next[7] = (pe[P_YZ] + pe[P_WX]) <<< 1;
        num3_next[8] = (pe[P_WW] + pe[P_ZZ]) - (pe[P_XX] + pe[P_YY]);
    end

    // ------------------------------------------------------------------
    // divider: stage 0 takes magnitudes and the integer bit, stages
    // 1..QUO_STEPS each produce one fraction bit
    // ------------------------------------------------------------------
    logic [REM_W-1:0] rem_reg  [QUO_STEPS+1][N_ELEM];
    logic [QUO_W-1:0] quo_reg  [QUO_STEPS+1][N_ELEM];
    logic             neg_reg  [QUO_STEPS+1][N_ELEM];
    logic [DEN_W-1:0] den_reg  [QUO_STEPS+1];
    logic             zero_reg [QUO_STEPS+1];
    logic             v_reg    [QUO_STEPS+1];

    logic [REM_W-1:0] rem_next [QUO_STEPS+1][N_ELEM];
    logic [QUO_W-1:0] quo_next [QUO_STEPS+1][N_ELEM];
    logic [NUM_W-1:0] mag0;
    logic [NUM_W-1:0] den0;
    logic [REM_W-1:0] sh;
    logic [REM_W-1:0] dk;
    logic             bit0;

    always_comb begin
        den0 = NUM_W'(den3_reg);
        for (int j = 0; j < N_ELEM; j++) begin
            mag0 = num3_reg[j][NUM_W-1] ? NUM_W'(-num3_reg[j]) : NUM_W'(num3_reg[j]);
            if (mag0 > den0) begin
                mag0 = den0;
            end
            bit0 = (mag0 >= den0);
            rem_next[0][j] = bit0 ? '0 : REM_W'(mag0);
            quo_next[0][j] = QUO_W'(bit0);
        end
        for (int k = 1; k <= QUO_STEPS; k++) begin
            dk = REM_W'(den_reg[k-1]);
            for (int j = 0; j < N_ELEM; j++) begin
                sh = rem_reg[k-1][j] << 1;
                if (sh >= dk) begin
                    rem_next[k][j] = sh - dk;
                    quo_next[k][j] = {quo_reg[k-1][j][QUO_W-2:0], 1'b1};
                end else begin
                    rem_next[k][j] = sh;
                    quo_next[k][j] = {quo_reg[k-1][j][QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // pipeline registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            for (int k = 0; k <= QUO_STEPS; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v_reg[0] <= v3_reg;
            for (int k = 1; k <= QUO_STEPS; k++) begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_reg    <= c1_next;
            zero1_reg <= zero1_next;
            for (int i = 0; i < N_PROD; i++) begin
                p2_reg[i] <= full_p[i][PROD_W-1:0];
            end
            zero2_reg <= zero1_reg;
            num3_reg  <= num3_next;
            den3_reg  <= den3_next;
            zero3_reg <= zero2_reg;
            den_reg[0]  <= den3_reg;
            zero_reg[0] <= zero3_reg;
            for (int j = 0; j < N_ELEM; j++) begin
                neg_reg[0][j] <= num3_reg[j][NUM_W-1];
            end
            for (int k = 1; k <= QUO_STEPS; k++) begin
                den_reg[k]  <= den_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
            end
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    // ------------------------------------------------------------------
    // rounding (ties away from zero), sign and identity override
    // ------------------------------------------------------------------
    localparam logic signed [ELEM_W-1:0] ONE = ELEM_W'(1) << OUT_FRAC_BITS;

    logic [QUO_W:0]           q_inc;
    logic [MAG_W-1:0]         rmag;
    logic signed [ELEM_W-1:0] e [N_ELEM];
    rot_out_t                 res;

    always_comb begin
        for (int j = 0; j < N_ELEM; j++) begin
            q_inc = {1'b0, quo_reg[QUO_STEPS][j]} + (QUO_W+1)'(1);
            rmag  = q_inc[MAG_W:1];
            e[j]  = neg_reg[QUO_STEPS][j] ? -ELEM_W'(rmag) : ELEM_W'(rmag);
        end
        if (zero_reg[QUO_STEPS]) begin
            for (int j = 0; j < N_ELEM; j++) begin
                e[j] = '0;
            end
            e[0] = ONE;
            e[4] = ONE;
            e[8] = ONE;
        end
        res.elem_00     = e[0];
        res.elem_01     = e[1];
        res.elem_02     = e[2];
        res.elem_10     = e[3];
        res.elem_11     = e[4];
        res.elem_12     = e[5];
        res.elem_20     = e[6];
        res.elem_21     = e[7];
        res.elem_22     = e[8];
        res.zero_length = zero_reg[QUO_STEPS];
    end

    // ------------------------------------------------------------------
    // output register and skid register
    // ------------------------------------------------------------------
    logic     m_valid_reg;
    rot_out_t m_data_reg;
    rot_out_t skid_reg;
    logic     out_free;
    logic     pipe_out;

    assign out_free = !m_valid_reg || m_ready;
    assign pipe_out = en && v_reg[QUO_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            skid_v_reg  <= 1'b0;
        end else begin
            if (out_free) begin
                m_valid_reg <= skid_v_reg || pipe_out;
            end
            if (skid_v_reg) begin
                if (out_free) begin
                    skid_v_reg <= 1'b0;
                end
            end else if (pipe_out && !out_free) begin
                skid_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            m_data_reg <= skid_v_reg ? skid_reg : res;
        end
        if (!skid_v_reg && pipe_out && !out_free) begin
            skid_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
